// File: rtl/core/excrt_congruence_merger_top_assert.svh
// Assertion macros for the congruence merger top level.
`ifndef EXCRT_CONGRUENCE_MERGER_TOP_ASSERT_SVH
`define EXCRT_CONGRUENCE_MERGER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define EXCRT_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("excrt check failed");
// Implication with a check on the next cycle.
`define EXCRT_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("excrt check failed");
`endif

// File: rtl/core/excrt_pkg.sv
// Package: widths, status codes, sequencer states and the shared ALU ops.
package excrt_pkg;
    localparam int WB = 63;
    localparam int CW = $clog2(WB + 2);
    typedef logic [WB-1:0] word_t;
    typedef logic [CW-1:0] cnt_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSOL   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ALU_DIV,
        ALU_MULMOD,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        word_t   a;
        word_t   b;
        word_t   m;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        word_t quo;
        word_t rem;
        logic  ovf;
    } alu_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_R, S_RED_R_W,
        S_RED_C, S_RED_C_W,
        S_GCD, S_GCD_W,
        S_CDIV, S_CDIV_W,
        S_SDIV, S_SDIV_W,
        S_LCM, S_LCM_W,
        S_CMD, S_CMD_W,
        S_INV_RED, S_INV_RED_W,
        S_INV_DIV, S_INV_DIV_W,
        S_INV_MUL, S_INV_MUL_W,
        S_X0, S_X0_W,
        S_ADD, S_ADD_W,
        S_OUT
    } state_t;
endpackage

// File: rtl/core/excrt_alu.sv
// Shared bit-serial unit: restoring divide, add-and-double mulmod, shift-add multiply.
module excrt_alu
    import excrt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);
    logic    busy_reg, busy_next;
    alu_op_t op_reg, op_next;
    word_t   a_reg, a_next;
    word_t   b_reg, b_next;
    word_t   m_reg, m_next;
    word_t   acc_reg, acc_next;
    logic    ovf_reg, ovf_next;
    logic    done_reg, done_next;
    cnt_t    cnt_reg, cnt_next;

    logic [WB:0] trial;
    logic [WB:0] sum;
    logic [WB:0] dbl;
    logic [WB:0] mac;

    always_comb begin
        trial = {acc_reg, a_reg[WB-1]} - {1'b0, b_reg};
        sum   = {1'b0, acc_reg} + {1'b0, a_reg};
        if (sum >= {1'b0, m_reg}) sum = sum - {1'b0, m_reg};
        dbl   = {1'b0, a_reg} + {1'b0, a_reg};
        if (dbl >= {1'b0, m_reg}) dbl = dbl - {1'b0, m_reg};
        mac   = {1'b0, acc_reg} + {1'b0, a_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                op_next   = req.op;
                a_next    = req.a;
                b_next    = req.b;
                m_next    = req.m;
                acc_next  = '0;
                ovf_next  = 1'b0;
                cnt_next  = CW'(WB);
            end
        end else begin
            case (op_reg)
                ALU_DIV: begin
                    // a shifts out dividend bits, receives quotient bits
                    if (!trial[WB]) begin
                        acc_next = trial[WB-1:0];
                        a_next   = {a_reg[WB-2:0], 1'b1};
                    end else begin
                        acc_next = {acc_reg[WB-2:0], a_reg[WB-1]};
                        a_next   = {a_reg[WB-2:0], 1'b0};
                    end
                end
                ALU_MULMOD: begin
                    if (b_reg[0]) acc_next = sum[WB-1:0];
                    a_next = dbl[WB-1:0];
                    b_next = b_reg >> 1;
                end
                ALU_MUL: begin
                    if (b_reg[0]) begin
                        acc_next = mac[WB-1:0];
                        if (mac[WB]) ovf_next = 1'b1;
                    end
                    if (a_reg[WB-1] && (b_reg >> 1) != '0) ovf_next = 1'b1;
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                default: ;
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        ovf_reg <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (op_reg == ALU_DIV) ? a_reg : acc_reg;
    assign rsp.rem  = acc_reg;
    assign rsp.ovf  = ovf_reg;
endmodule

// File: rtl/core/excrt_congruence_merger_top.sv
// Top level: congruence merger (extended CRT) sequencer around one shared ALU.
//
//  channel | ports                                   | dir
//  s_      | s_valid s_ready s_modulus s_residue      | in
//          | s_last_pair                              |
//  m_      | m_valid m_ready m_solution m_status      | out
//          | m_combined_mod_out m_system_done         |
//
// Work: every ALU op handles one bit per cycle, with a sequencing state
// before it. A merge runs about 9 ops plus 3 per extended-gcd round; a
// beat with a sticky failure goes straight to the output and runs no op.
// The shared ALU's single bit-serial datapath sets the run time of a beat.
// Reset: synchronous, active low; state returns to modulus 1, residue 0, ok.
// Stalls: s_ready is high only in idle; a result waits in the output
// register while m_ready is low, and the next beat starts after it is taken.
module excrt_congruence_merger_top
    import excrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [62:0] s_modulus,
    input  logic [62:0] s_residue,
    input  logic        s_last_pair,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [62:0] m_solution,
    output logic [62:0] m_combined_mod_out,
    output logic [1:0]  m_status,
    output logic        m_system_done
);
`include "excrt_congruence_merger_top_assert.svh"

    state_t state_reg, state_next;
    word_t  cm_reg, cm_next;     // combined modulus
    word_t  cr_reg, cr_next;     // combined residue
    logic [1:0] fail_reg, fail_next;
    word_t  m_in_reg, m_in_next;
    word_t  r_in_reg, r_in_next;
    logic   last_reg, last_next;
    word_t  c_reg, c_next;
    word_t  d_reg, d_next;       // gcd / scratch
    word_t  t_reg, t_next;       // gcd partner
    word_t  sm_reg, sm_next;     // step modulus
    word_t  nl_reg, nl_next;
    word_t  r0_reg, r0_next;
    word_t  r1_reg, r1_next;
    word_t  s0_reg, s0_next;
    word_t  s1_reg, s1_next;
    word_t  q_reg, q_next;
    word_t  sol_reg, sol_next;
    word_t  held_reg, held_next;
    logic   ov_reg, ov_next;

    alu_req_t req;
    alu_rsp_t rsp;

    excrt_alu u_alu (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    logic [WB:0] addw;
    logic [WB:0] subw;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_valid) state_next = (fail_reg != ST_OK) ? S_OUT : S_RED_R;
            S_RED_R:     state_next = S_RED_R_W;
            S_RED_R_W:   if (rsp.done) state_next = S_RED_C;
            S_RED_C:     state_next = S_RED_C_W;
            S_RED_C_W:   if (rsp.done) state_next = S_GCD;
            S_GCD:       state_next = (t_reg == '0) ? S_CDIV : S_GCD_W;
            S_GCD_W:     if (rsp.done) state_next = S_GCD;
            S_CDIV:      state_next = S_CDIV_W;
            S_CDIV_W:    if (rsp.done) state_next = (rsp.rem != '0) ? S_OUT : S_SDIV;
            S_SDIV:      state_next = S_SDIV_W;
            S_SDIV_W:    if (rsp.done) state_next = S_LCM;
            S_LCM:       state_next = S_LCM_W;
            S_LCM_W:     if (rsp.done) state_next = rsp.ovf ? S_OUT
                                                  : ((sm_reg > WB'(1)) ? S_CMD : S_ADD);
            S_CMD:       state_next = S_CMD_W;
            S_CMD_W:     if (rsp.done) state_next = S_INV_RED;
            S_INV_RED:   state_next = S_INV_RED_W;
            S_INV_RED_W: if (rsp.done) state_next = S_INV_DIV;
            S_INV_DIV:   state_next = (r1_reg == '0) ? S_X0 : S_INV_DIV_W;
            S_INV_DIV_W: if (rsp.done) state_next = S_INV_MUL;
            S_INV_MUL:   state_next = S_INV_MUL_W;
            S_INV_MUL_W: if (rsp.done) state_next = S_INV_DIV;
            S_X0:        state_next = S_X0_W;
            S_X0_W:      if (rsp.done) state_next = S_ADD;
            S_ADD:       state_next = S_ADD_W;
            S_ADD_W:     if (rsp.done) state_next = S_OUT;
            S_OUT:       if (m_ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // ALU requests
    always_comb begin
        req.start = 1'b0;
        req.op    = ALU_DIV;
        req.a     = '0;
        req.b     = WB'(1);
        req.m     = WB'(1);
        case (state_reg)
            S_RED_R:   begin req.start = 1'b1; req.a = r_in_reg; req.b = m_in_reg; end
            S_RED_C:   begin req.start = 1'b1; req.a = cr_reg;   req.b = m_in_reg; end
            S_GCD:     begin req.start = (t_reg != '0); req.a = d_reg; req.b = t_reg; end
            S_CDIV:    begin req.start = 1'b1; req.a = c_reg;    req.b = d_reg; end
            S_SDIV:    begin req.start = 1'b1; req.a = m_in_reg; req.b = d_reg; end
            S_LCM:     begin req.start = 1'b1; req.op = ALU_MUL; req.a = cm_reg;
                             req.b = sm_reg; end
            S_CMD:     begin req.start = 1'b1; req.a = cm_reg;   req.b = d_reg; end
            S_INV_RED: begin req.start = 1'b1; req.a = q_reg;    req.b = sm_reg; end
            S_INV_DIV: begin req.start = (r1_reg != '0); req.a = r0_reg; req.b = r1_reg; end
            S_INV_MUL: begin req.start = 1'b1; req.op = ALU_MULMOD; req.a = q_reg;
                             req.b = s1_reg; req.m = sm_reg; end
            S_X0:      begin req.start = 1'b1; req.op = ALU_MULMOD; req.a = s0_reg;
                             req.b = c_reg; req.m = sm_reg; end
            S_ADD:     begin req.start = 1'b1; req.op = ALU_MULMOD; req.a = cm_reg;
                             req.b = q_reg; req.m = nl_reg; end
            default: ;
        endcase
    end

    // Datapath registers
    always_comb begin
        cm_next = cm_reg;  cr_next = cr_reg;  fail_next = fail_reg;
        m_in_next = m_in_reg; r_in_next = r_in_reg; last_next = last_reg;
        c_next = c_reg; d_next = d_reg; t_next = t_reg; sm_next = sm_reg;
        nl_next = nl_reg; r0_next = r0_reg; r1_next = r1_reg;
        s0_next = s0_reg; s1_next = s1_reg; q_next = q_reg;
        sol_next = sol_reg; held_next = held_reg; ov_next = ov_reg;
        addw = '0;
        subw = '0;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                m_in_next = (s_modulus[WB-1:0] == '0) ? WB'(1) : s_modulus[WB-1:0];
                r_in_next = s_residue[WB-1:0];
                last_next = s_last_pair;
                held_next = cm_reg;
                sol_next  = '0;
            end
            S_RED_R_W: if (rsp.done) c_next = rsp.rem;
            S_RED_C_W: if (rsp.done) begin
                subw = {1'b0, c_reg} + {1'b0, m_in_reg} - {1'b0, rsp.rem};
                if (subw >= {1'b0, m_in_reg}) subw = subw - {1'b0, m_in_reg};
                c_next = subw[WB-1:0];
                d_next = cm_reg;
                t_next = m_in_reg;
            end
            S_GCD_W: if (rsp.done) begin d_next = t_reg; t_next = rsp.rem; end
            S_CDIV_W: if (rsp.done) begin
                if (rsp.rem != '0) fail_next = ST_NOSOL;
                c_next = rsp.quo;
            end
            S_SDIV_W: if (rsp.done) sm_next = rsp.quo;
            S_LCM_W: if (rsp.done) begin
                if (rsp.ovf) fail_next = ST_OVERFLOW;
                nl_next = rsp.rem;
                q_next  = '0;
            end
            S_CMD_W: if (rsp.done) q_next = rsp.quo;
            S_INV_RED_W: if (rsp.done) begin
                r0_next = rsp.rem; r1_next = sm_reg;
                s0_next = (sm_reg == WB'(1)) ? '0 : WB'(1);
                s1_next = '0;
            end
            S_INV_DIV_W: if (rsp.done) begin
                q_next = rsp.quo; r0_next = r1_reg; r1_next = rsp.rem;
            end
            S_INV_MUL_W: if (rsp.done) begin
                addw = {1'b0, s0_reg} + {1'b0, sm_reg} - {1'b0, rsp.rem};
                if (addw >= {1'b0, sm_reg}) addw = addw - {1'b0, sm_reg};
                s0_next = s1_reg;
                s1_next = addw[WB-1:0];
            end
            S_X0_W: if (rsp.done) q_next = rsp.rem;
            S_ADD_W: if (rsp.done) begin
                addw = {1'b0, cr_reg} + {1'b0, rsp.rem};
                if (addw >= {1'b0, nl_reg}) addw = addw - {1'b0, nl_reg};
                if (addw >= {1'b0, nl_reg}) addw = addw - {1'b0, nl_reg};
                cr_next   = addw[WB-1:0];
                cm_next   = nl_reg;
                held_next = nl_reg;
                sol_next  = addw[WB-1:0];
            end
            S_OUT: if (m_ready && last_reg) begin
                cm_next = WB'(1); cr_next = '0; fail_next = ST_OK;
            end
            default: ;
        endcase
        ov_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cm_reg    <= WB'(1);
            cr_reg    <= '0;
            fail_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            cm_reg    <= cm_next;
            cr_reg    <= cr_next;
            fail_reg  <= fail_next;
        end
        m_in_reg <= m_in_next; r_in_reg <= r_in_next; last_reg <= last_next;
        c_reg <= c_next; d_reg <= d_next; t_reg <= t_next; sm_reg <= sm_next;
        nl_reg <= nl_next; r0_reg <= r0_next; r1_reg <= r1_next;
        s0_reg <= s0_next; s1_reg <= s1_next; q_reg <= q_next;
        sol_reg <= sol_next; held_reg <= held_next; ov_reg <= ov_next;
    end

    // Outputs
    always_comb begin
        s_ready = (state_reg == S_IDLE);
        m_valid = (state_reg == S_OUT) && !ov_reg;
    end

    assign m_solution         = (fail_reg == ST_OK) ? sol_reg : '0;
    assign m_combined_mod_out = held_reg;
    assign m_status           = fail_reg;
    assign m_system_done      = last_reg;

    `EXCRT_ASSERT_IMP(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    `EXCRT_ASSERT_IMP(a_fail_zero, aclk, aresetn, m_valid && m_status != ST_OK,
        m_solution == '0)
    `EXCRT_ASSERT_NEXT(a_last_clears, aclk, aresetn,
        m_valid && m_ready && m_system_done, m_status == ST_OK && s_ready)
endmodule
